### hw/rtl/rwat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rwat_pkg;

    localparam int RPM_W      = 20;
    localparam int WIDTH_W    = 10;
    localparam int EDGE_W     = 13;
    localparam int NUM_PAIRS  = 5;
    localparam int DIV_STEPS  = 20;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 10'd80;

    // ceil(600000 / p) is floor(599999 / p) + 1 for any nonzero p.
    localparam logic [RPM_W-1:0] DIV_DIVIDEND = 20'd599999;

    typedef enum logic [2:0] {
        OP_FINE_TICK   = 3'd0,
        OP_PULSE       = 3'd1,
        OP_COARSE_TICK = 3'd2,
        OP_READ        = 3'd3,
        OP_RESTART     = 3'd4
    } rwat_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_EVAL,
        ST_WRB,
        ST_DONE
    } rwat_state_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [2:0] test_select;
        logic       normal_mode;
        logic       boost_mode;
        logic [3:0] record_index;
    } rwat_item_t;

    typedef struct packed {
        logic [19:0] speed_rpm;
        logic        speed_updated;
        logic        period_error;
        logic [15:0] elapsed_ticks;
        logic        timing_active;
        logic [15:0] record_value;
        logic        beep_request;
    } rwat_result_t;

    function automatic logic [EDGE_W-1:0] low_edge(input logic [2:0] t);
        logic [EDGE_W-1:0] e;
        unique case (t)
            3'd0:    e = 13'd2500;
            3'd1:    e = 13'd3000;
            3'd2:    e = 13'd3000;
            3'd3:    e = 13'd3500;
            3'd4:    e = 13'd3500;
            default: e = '0;
        endcase
        return e;
    endfunction

    function automatic logic [EDGE_W-1:0] high_edge(input logic [2:0] t);
        logic [EDGE_W-1:0] e;
        unique case (t)
            3'd0:    e = 13'd4000;
            3'd1:    e = 13'd5000;
            3'd2:    e = 13'd4500;
            3'd3:    e = 13'd4000;
            3'd4:    e = 13'd3750;
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/rwat_div.sv
`timescale 1ns / 1ps
`default_nettype none

module rwat_div
    import rwat_pkg::*;
#(
    parameter int CW = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [CW-1:0]    divisor,
    output logic                  done,
    output logic [RPM_W-1:0]      quotient
);

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [RPM_W-1:0]  dvd_reg, dvd_next;
    logic [RPM_W-1:0]  quot_reg, quot_next;
    logic [CW:0]       trial;
    logic [CW:0]       diff;
    logic              fits;

    // Restoring division, one quotient bit per cycle. The remainder stays
    // below the divisor, so the trial value never needs more than CW+1 bits.
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[RPM_W-1]};
        diff      = trial - {1'b0, divisor};
        fits      = (trial >= {1'b0, divisor});
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvd_next  = DIV_DIVIDEND;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[CW-1:0] : trial[CW-1:0];
            dvd_next  = {dvd_reg[RPM_W-2:0], 1'b0};
            quot_next = {quot_reg[RPM_W-2:0], fits};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

### hw/rtl/rpm_window_acceleration_timer.sv
// Engine acceleration timer. Each item beat carries one event: a 0.1 ms tick,
// a speed-sensor pulse, a 10 ms tick, a record read or a restart, and yields
// exactly one result beat with the current speed, timer and record status.
// Every second pulse closes a period; a nonzero period sets the speed to
// ceil(600000 / period) via a bit-serial divider making one quotient bit per
// cycle. An item closing a nonzero period first passes the divide state (20
// divider steps); then records are read, the item is evaluated, a boosted
// record gets a write state of its own (single write port), the result is
// loaded. One item is in work at a time; a finished result waits
// in the output register while the next item is taken. The ten time records
// read as empty after reset through per-entry valid flags, so there is no
// clearing pass. window_width may be written at any time the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module rpm_window_acceleration_timer
    import rwat_pkg::*;
#(
    parameter int NUM_TESTS   = 5,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [WIDTH_W-1:0] cfg_data,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire rwat_item_t         item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output rwat_result_t            result
);

    localparam int NT   = NUM_TESTS;
    localparam int CW   = COUNT_WIDTH;
    localparam int NREC = 2 * NUM_TESTS;
    localparam int AW   = $clog2(NREC);

    rwat_state_t       state_reg, state_next;
    logic [WIDTH_W-1:0] win_width_reg, win_width_next;
    logic              phase_reg, phase_next;
    logic [CW-1:0]     period_reg, period_next;
    logic [RPM_W-1:0]  rpm_reg, rpm_next;
    logic [CW-1:0]     elapsed_reg, elapsed_next;
    logic              running_reg, running_next;
    logic [NT-1:0]     armed_reg, armed_next;
    rwat_item_t        item_reg, item_next;
    logic              upd_reg, upd_next;
    logic              perr_reg, perr_next;
    logic              beep_reg, beep_next;
    logic [CW-1:0]     recval_reg, recval_next;
    logic [NREC-1:0]   vld_reg, vld_next;
    rwat_result_t      out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [CW-1:0]     rec_mem [NREC];
    logic [CW-1:0]     rd_a_reg, rd_b_reg;
    logic              va_reg, vb_reg;

    logic              accept;
    logic              div_start;
    logic              div_done;
    logic [RPM_W-1:0]  div_quot;
    logic              mem_re;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CW-1:0]     mem_wdata;
    logic [AW-1:0]     rd_addr_a, rd_addr_b;
    logic              out_load;

    logic [2:0]        t_idx;
    logic              test_ok;
    logic              is_check;
    logic [NT-1:0]     mask;
    logic [AW-1:0]     rn, rb;
    logic [CW-1:0]     rec_n, rec_b;
    logic [EDGE_W-1:0] lo_base, hi_base;
    logic              lo_in, hi_in;
    logic              hit_lo, hit_hi;
    logic [NT-1:0]     armed_lo;
    logic [CW-1:0]     elapsed_lo;
    logic              cap_n, cap_b;
    logic              rd_ok;

    rwat_div #(
        .CW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (period_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Window evaluation for the item held in item_reg, using the records
    // fetched in the read state.
    always_comb
    begin
        t_idx    = item_reg.test_select - 3'd1;
        test_ok  = (item_reg.test_select != 3'd0)
                && (32'(item_reg.test_select) <= 32'(NUM_TESTS))
                && (item_reg.test_select <= 3'(NUM_PAIRS));
        is_check = (item_reg.opcode == OP_FINE_TICK) || (item_reg.opcode == OP_PULSE)
                || (item_reg.opcode == OP_COARSE_TICK);
        mask     = NT'(1) << t_idx;
        rn       = AW'(t_idx);
        rb       = AW'(t_idx) + AW'(NUM_TESTS);
        rec_n    = va_reg ? rd_a_reg : '0;
        rec_b    = vb_reg ? rd_b_reg : '0;
        lo_base  = low_edge(t_idx);
        hi_base  = high_edge(t_idx);
        lo_in    = (rpm_reg > RPM_W'(lo_base))
                && (rpm_reg < RPM_W'(lo_base) + RPM_W'(win_width_reg));
        hi_in    = (rpm_reg > RPM_W'(hi_base))
                && (rpm_reg < RPM_W'(hi_base) + RPM_W'(win_width_reg));
        hit_lo   = is_check && test_ok && lo_in;
        armed_lo = hit_lo ? (armed_reg | mask) : armed_reg;
        elapsed_lo = hit_lo ? '0 : elapsed_reg;
        hit_hi   = is_check && test_ok && hi_in && ((armed_lo & mask) != '0);
        cap_n    = hit_hi && item_reg.normal_mode && (rec_n == '0);
        cap_b    = hit_hi && item_reg.boost_mode && (rec_b == '0);
        rd_ok    = ({28'd0, item_reg.record_index} < 32'(NREC));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = div_start ? ST_DIV : ST_READ;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_EVAL;
            ST_EVAL: state_next = cap_b ? ST_WRB : ST_DONE;
            ST_WRB:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_ready = (state_reg == ST_IDLE);
        accept     = item_valid && item_ready;
        div_start  = accept && (item.opcode == OP_PULSE) && phase_reg
                  && (period_reg != '0);
        mem_re     = (state_reg == ST_READ);
        rd_addr_a  = (item_reg.opcode == OP_READ) ? AW'(item_reg.record_index) : rn;
        rd_addr_b  = rb;
        mem_we     = 1'b0;
        mem_waddr  = rn;
        mem_wdata  = elapsed_lo;
        out_load   = (state_reg == ST_DONE) && (!out_valid_reg || result_ready);
        unique case (state_reg)
            ST_EVAL: mem_we = cap_n;
            ST_WRB:
            begin
                mem_we    = 1'b1;
                mem_waddr = rb;
                mem_wdata = elapsed_reg;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_comb
    begin
        win_width_next = cfg_write ? cfg_data : win_width_reg;
        phase_next     = phase_reg;
        period_next    = period_reg;
        rpm_next       = rpm_reg;
        elapsed_next   = elapsed_reg;
        running_next   = running_reg;
        armed_next     = armed_reg;
        item_next      = item_reg;
        upd_next       = upd_reg;
        perr_next      = perr_reg;
        beep_next      = beep_reg;
        recval_next    = recval_reg;
        vld_next       = vld_reg;

        if (accept)
        begin
            item_next   = item;
            upd_next    = 1'b0;
            perr_next   = 1'b0;
            beep_next   = 1'b0;
            recval_next = '0;
            unique case (item.opcode)
                OP_FINE_TICK:
                begin
                    if (phase_reg && !(&period_reg))
                    begin
                        period_next = period_reg + CW'(1);
                    end
                end
                OP_PULSE:
                begin
                    if (!phase_reg)
                    begin
                        phase_next  = 1'b1;
                        period_next = '0;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        upd_next   = 1'b1;
                        perr_next  = (period_reg == '0);
                    end
                end
                OP_COARSE_TICK:
                begin
                    if (running_reg && !(&elapsed_reg))
                    begin
                        elapsed_next = elapsed_reg + CW'(1);
                    end
                end
                OP_RESTART:
                begin
                    phase_next   = 1'b0;
                    period_next  = '0;
                    elapsed_next = '0;
                    running_next = 1'b0;
                    armed_next   = '0;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (div_done)
        begin
            rpm_next = div_quot + RPM_W'(1);
        end

        if (state_reg == ST_EVAL)
        begin
            if (item_reg.opcode == OP_READ)
            begin
                recval_next = rd_ok ? rec_n : '0;
            end
            elapsed_next = elapsed_lo;
            armed_next   = hit_hi ? (armed_lo & ~mask) : armed_lo;
            if (hit_hi)
            begin
                running_next = 1'b0;
            end
            else if (hit_lo)
            begin
                running_next = 1'b1;
            end
            if (cap_n || cap_b)
            begin
                recval_next = elapsed_lo;
            end
            beep_next = (hit_lo && ((rec_n == '0) || (rec_b == '0))) || cap_n || cap_b;
        end

        if (mem_we)
        begin
            vld_next[mem_waddr] = 1'b1;
        end

        out_next = out_reg;
        if (out_load)
        begin
            out_next.speed_rpm     = rpm_reg;
            out_next.speed_updated = upd_reg;
            out_next.period_error  = perr_reg;
            out_next.elapsed_ticks = 16'(elapsed_reg);
            out_next.timing_active = running_reg;
            out_next.record_value  = 16'(recval_reg);
            out_next.beep_request  = beep_reg;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_width_reg <= WIDTH_RESET;
            phase_reg     <= 1'b0;
            period_reg    <= '0;
            rpm_reg       <= '0;
            elapsed_reg   <= '0;
            running_reg   <= 1'b0;
            armed_reg     <= '0;
            upd_reg       <= 1'b0;
            perr_reg      <= 1'b0;
            beep_reg      <= 1'b0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_width_reg <= win_width_next;
            phase_reg     <= phase_next;
            period_reg    <= period_next;
            rpm_reg       <= rpm_next;
            elapsed_reg   <= elapsed_next;
            running_reg   <= running_next;
            armed_reg     <= armed_next;
            upd_reg       <= upd_next;
            perr_reg      <= perr_next;
            beep_reg      <= beep_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        recval_reg <= recval_next;
        out_reg    <= out_next;
    end

    // Time record store: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rec_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_a_reg <= rec_mem[rd_addr_a];
            rd_b_reg <= rec_mem[rd_addr_b];
            va_reg   <= vld_reg[rd_addr_a];
            vb_reg   <= vld_reg[rd_addr_b];
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef ASSERT_OFF
    a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_wrb_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRB |-> $past(state_reg) == ST_EVAL)
        else $error("boosted record write not preceded by evaluation");

    a_err_is_update: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.period_error |-> result.speed_updated)
        else $error("period error reported without a completed period");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.opcode == OP_RESTART |=>
            !running_reg && armed_reg == '0 && !phase_reg && elapsed_reg == '0)
        else $error("restart left timer or arming state behind");
`endif

endmodule

`default_nettype wire

### test/rpm_window_acceleration_timer_tb.sv
`timescale 1ns / 1ps

module rpm_window_acceleration_timer_tb;
    import rwat_pkg::*;

    localparam int TESTS = 5;
    localparam int NUM_RECORDS = 2 * TESTS;
    localparam int COUNT_TOP = 65535;
    localparam int RPM_NUMERATOR = 600000;
    localparam int LONG_HOLD = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RUN_BUDGET = 200;
    localparam int STRETCH_TICKS = 30;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [WIDTH_W-1:0] cfg_data = '0;
    logic item_valid = 1'b0;
    logic item_ready;
    rwat_item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    rwat_result_t result;

    // Speed windows per test: a speed s is inside when edge < s < edge + width.
    int low_rpm[NUM_PAIRS] = '{2500, 3000, 3000, 3500, 3500};
    int high_rpm[NUM_PAIRS] = '{4000, 5000, 4500, 4000, 3750};

    // Expected state of the timer.
    int width_now = 80;
    bit phase_open;
    int tick_count;
    int speed_now;
    int elapsed_now;
    bit timer_on;
    bit [TESTS-1:0] armed_mask;
    int records[NUM_RECORDS];

    rwat_item_t pending_items[$];
    rwat_result_t results_due[$];
    bit item_taken;
    bit queued_phase;
    int beats_queued;
    int error_count;
    int quiet_cycles;
    int sender_idle_pct = 21;
    int receiver_stall_pct = 56;
    int holds_asked;
    int holds_done;
    int hold_left;

    rpm_window_acceleration_timer dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    always #5 clk = ~clk;

    task automatic advance_timer(input rwat_item_t beat, output rwat_result_t want);
        int t;
        bit check;
        want = '0;
        check = 1'b0;
        case (beat.opcode)
            OP_FINE_TICK:
            begin
                if (phase_open && tick_count < COUNT_TOP)
                    tick_count++;
                check = 1'b1;
            end
            OP_PULSE:
            begin
                if (!phase_open)
                begin
                    phase_open = 1'b1;
                    tick_count = 0;
                end
                else
                begin
                    phase_open = 1'b0;
                    want.speed_updated = 1'b1;
                    if (tick_count == 0)
                        want.period_error = 1'b1;
                    else
                        speed_now = (RPM_NUMERATOR + tick_count - 1) / tick_count;
                end
                check = 1'b1;
            end
            OP_COARSE_TICK:
            begin
                if (timer_on && elapsed_now < COUNT_TOP)
                    elapsed_now++;
                check = 1'b1;
            end
            OP_READ:
            begin
                if (beat.record_index < NUM_RECORDS)
                    want.record_value = 16'(records[beat.record_index]);
            end
            OP_RESTART:
            begin
                phase_open = 1'b0;
                tick_count = 0;
                elapsed_now = 0;
                timer_on = 1'b0;
                armed_mask = '0;
            end
            default:
            begin
            end
        endcase

        if (check && beat.test_select >= 1 && beat.test_select <= TESTS)
        begin
            t = beat.test_select - 1;
            if (speed_now > low_rpm[t] && speed_now < low_rpm[t] + width_now)
            begin
                timer_on = 1'b1;
                elapsed_now = 0;
                armed_mask[t] = 1'b1;
                if (records[t] == 0 || records[t + TESTS] == 0)
                    want.beep_request = 1'b1;
            end
            // Arming and capture can land on the same beat when windows overlap.
            if (speed_now > high_rpm[t] && speed_now < high_rpm[t] + width_now
                    && armed_mask[t])
            begin
                timer_on = 1'b0;
                armed_mask[t] = 1'b0;
                if (beat.normal_mode && records[t] == 0)
                begin
                    records[t] = elapsed_now;
                    want.record_value = 16'(elapsed_now);
                    want.beep_request = 1'b1;
                end
                if (beat.boost_mode && records[t + TESTS] == 0)
                begin
                    records[t + TESTS] = elapsed_now;
                    want.record_value = 16'(elapsed_now);
                    want.beep_request = 1'b1;
                end
            end
        end

        want.speed_rpm = 20'(speed_now);
        want.elapsed_ticks = 16'(elapsed_now);
        want.timing_active = timer_on;
    endtask

    task automatic flag_field(input string name, input int want, input int got);
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        error_count++;
    endtask

    task automatic compare_beat(input rwat_result_t want, input rwat_result_t got);
        if (got.speed_rpm !== want.speed_rpm)
            flag_field("speed_rpm", want.speed_rpm, got.speed_rpm);
        if (got.speed_updated !== want.speed_updated)
            flag_field("speed_updated", want.speed_updated, got.speed_updated);
        if (got.period_error !== want.period_error)
            flag_field("period_error", want.period_error, got.period_error);
        if (got.elapsed_ticks !== want.elapsed_ticks)
            flag_field("elapsed_ticks", want.elapsed_ticks, got.elapsed_ticks);
        if (got.timing_active !== want.timing_active)
            flag_field("timing_active", want.timing_active, got.timing_active);
        if (got.record_value !== want.record_value)
            flag_field("record_value", want.record_value, got.record_value);
        if (got.beep_request !== want.beep_request)
            flag_field("beep_request", want.beep_request, got.beep_request);
    endtask

    task automatic queue_beat(input logic [2:0] op, input int test, input bit nm,
                              input bit bm, input int ridx);
        rwat_item_t beat;
        beat.opcode = op;
        beat.test_select = 3'(test);
        beat.normal_mode = nm;
        beat.boost_mode = bm;
        beat.record_index = 4'(ridx);
        pending_items.push_back(beat);
        beats_queued++;
        if (op == OP_PULSE)
            queued_phase = !queued_phase;
        else if (op == OP_RESTART)
            queued_phase = 1'b0;
    endtask

    // One measured period of n fine ticks, with coarse ticks mixed in now and then.
    task automatic queue_period(input int n, input int test, input bit nm, input bit bm);
        if (queued_phase)
            queue_beat(OP_PULSE, 0, nm, bm, $urandom_range(15));
        queue_beat(OP_PULSE, test, nm, bm, $urandom_range(15));
        for (int i = 0; i < n; i++)
        begin
            queue_beat(OP_FINE_TICK, test, nm, bm, $urandom_range(15));
            if ($urandom_range(9) == 0)
                queue_beat(OP_COARSE_TICK, test, nm, bm, $urandom_range(15));
        end
        queue_beat(OP_PULSE, test, nm, bm, $urandom_range(15));
    endtask

    // Picks a tick count whose speed falls inside the given window, if any does.
    function automatic int ticks_for(input int base, input int span);
        int hits[$];
        int n_lo;
        int rpm;
        n_lo = RPM_NUMERATOR / (base + span);
        if (n_lo < 1)
            n_lo = 1;
        for (int n = RPM_NUMERATOR / base + 1; n >= n_lo; n--)
        begin
            rpm = (RPM_NUMERATOR + n - 1) / n;
            if (rpm > base && rpm < base + span)
                hits.push_back(n);
        end
        if (hits.size() == 0)
            return RPM_NUMERATOR / base;
        return hits[$urandom_range(hits.size() - 1)];
    endfunction

    // Low window, sometimes a speed in between, then the high window.
    task automatic queue_run(input int t);
        bit nm;
        bit bm;
        int n;
        nm = $urandom_range(1);
        bm = $urandom_range(1);
        if (!nm && !bm && $urandom_range(3) != 0)
            nm = 1'b1;
        queue_period(ticks_for(low_rpm[t - 1], width_now), t, nm, bm);
        if ($urandom_range(9) == 0)
            queue_beat(OP_RESTART, t, nm, bm, $urandom_range(15));
        if ($urandom_range(1))
            queue_period(2 * RPM_NUMERATOR / (low_rpm[t - 1] + high_rpm[t - 1]), t, nm, bm);
        n = ticks_for(high_rpm[t - 1], width_now);
        if ($urandom_range(4) == 0)
            n = n + int'($urandom_range(6)) - 3;
        queue_period(n, t, nm, bm);
        queue_beat(OP_READ, t, nm, bm, bm ? t - 1 + TESTS : t - 1);
    endtask

    task automatic queue_random(input int count);
        int stop_at;
        int pick;
        stop_at = beats_queued + count;
        while (beats_queued < stop_at)
        begin
            pick = $urandom_range(99);
            // A full run is a few hundred beats, so it only starts while that much is left.
            if (pick < 50 && stop_at - beats_queued < RUN_BUDGET)
                pick = 50 + int'($urandom_range(49));
            if (pick < 50)
                queue_run($urandom_range(1, TESTS));
            else if (pick < 70)
                queue_period($urandom_range(30), $urandom_range(7), $urandom_range(1),
                             $urandom_range(1));
            else if (pick < 80)
                queue_beat(OP_READ, $urandom_range(7), $urandom_range(1), $urandom_range(1),
                           $urandom_range(15));
            else if (pick < 85)
                queue_beat(OP_RESTART, $urandom_range(7), $urandom_range(1),
                           $urandom_range(1), $urandom_range(15));
            else
                queue_beat(3'($urandom_range(7)), $urandom_range(7), $urandom_range(1),
                           $urandom_range(1), $urandom_range(15));
        end
    endtask

    // Arms test t, lets both counters run for a stretch, then captures.
    task automatic queue_saturation(input int t);
        queue_period(ticks_for(low_rpm[t - 1], width_now), t, 1'b1, 1'b1);
        queue_beat(OP_PULSE, 0, 1'b1, 1'b1, $urandom_range(15));
        for (int i = 0; i < STRETCH_TICKS; i++)
        begin
            queue_beat(OP_FINE_TICK, 0, 1'b1, 1'b1, $urandom_range(15));
            queue_beat(OP_COARSE_TICK, 0, 1'b1, 1'b1, $urandom_range(15));
        end
        queue_beat(OP_PULSE, 0, 1'b1, 1'b1, $urandom_range(15));
        queue_period(ticks_for(high_rpm[t - 1], width_now), t, 1'b1, 1'b1);
        queue_beat(OP_READ, t, 1'b1, 1'b1, t - 1);
        queue_beat(OP_READ, t, 1'b1, 1'b1, t - 1 + TESTS);
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_items.size() != 0 || item_valid || results_due.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_window(input int w);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data <= WIDTH_W'(w);
        width_now = w;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    always @(negedge clk)
    begin : drive_items
        rwat_item_t next_beat;
        logic offer;
        offer = 1'b0;
        if (rst_n && !(item_valid && !item_taken))
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                next_beat = pending_items.pop_front();
                offer = 1'b1;
            end
            item_valid <= offer;
            if (offer)
                item <= next_beat;
        end
        item_taken = 1'b0;
    end

    always @(negedge clk)
    begin : drive_ready
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else if (holds_done != holds_asked)
        begin
            holds_done = holds_asked;
            hold_left = LONG_HOLD;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin : watch_ports
        rwat_result_t want;
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (result_valid && result_ready)
            begin
                moved = 1'b1;
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, result);
                    error_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    compare_beat(want, result);
                end
            end
            if (item_valid && item_ready)
            begin
                moved = 1'b1;
                advance_timer(item, want);
                results_due.push_back(want);
                item_taken = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("rpm_window_acceleration_timer_tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin : run_test
        int sat_test;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #1;

        // Directed beats at the reset window width.
        queue_beat(OP_READ, 0, 1'b0, 1'b0, 0);
        queue_beat(OP_READ, 0, 1'b0, 1'b0, 15);
        queue_beat(OP_READ, 5, 1'b1, 1'b1, NUM_RECORDS - 1);
        for (int k = int'(OP_SPARE_FIRST); k <= int'(OP_SPARE_LAST); k++)
            queue_beat(3'(k), 7, 1'b1, 1'b1, 15);
        queue_beat(OP_FINE_TICK, 1, 1'b0, 1'b0, 0);
        queue_beat(OP_PULSE, 1, 1'b1, 1'b0, 0);
        queue_beat(OP_PULSE, 1, 1'b1, 1'b0, 0);
        queue_beat(OP_PULSE, 6, 1'b0, 1'b1, 0);
        queue_beat(OP_FINE_TICK, 7, 1'b0, 1'b1, 0);
        queue_beat(OP_PULSE, 6, 1'b0, 1'b1, 0);
        queue_beat(OP_COARSE_TICK, 3, 1'b1, 1'b1, 0);
        queue_beat(OP_PULSE, 2, 1'b1, 1'b1, 0);
        queue_beat(OP_FINE_TICK, 2, 1'b1, 1'b1, 0);
        queue_beat(OP_RESTART, 2, 1'b1, 1'b1, 0);
        queue_beat(OP_PULSE, 4, 1'b0, 1'b0, 0);
        queue_beat(OP_FINE_TICK, 4, 1'b0, 1'b0, 0);
        queue_beat(OP_FINE_TICK, 4, 1'b0, 1'b0, 0);
        queue_beat(OP_FINE_TICK, 4, 1'b0, 1'b0, 0);
        queue_beat(OP_PULSE, 4, 1'b0, 1'b0, 0);
        queue_beat(OP_READ, 0, 1'b0, 1'b0, NUM_RECORDS);
        wait_idle();

        set_window(1023);
        queue_random(450);
        wait_idle();

        sender_idle_pct = 56;
        receiver_stall_pct = 21;
        set_window(1);
        queue_random(80);
        wait_idle();
        set_window($urandom_range(2, 400));
        queue_random(350);
        wait_idle();

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        set_window(80);
        // The receiver stalls for a long stretch while beats keep coming.
        holds_asked++;
        for (int k = 0; k < 40; k++)
            queue_beat(OP_READ, $urandom_range(7), $urandom_range(1), $urandom_range(1),
                       $urandom_range(15));
        wait_idle();

        sat_test = 2;
        for (int k = TESTS; k >= 1; k--)
            if (records[k - 1] == 0)
                sat_test = k;
        queue_saturation(sat_test);
        wait_idle();
        queue_random(100);
        wait_idle();

        repeat (40) @(posedge clk);
        if (error_count == 0 && results_due.size() == 0)
            $display("rpm_window_acceleration_timer_tb: PASS");
        else
            $display("rpm_window_acceleration_timer_tb: FAIL");
        $finish;
    end

endmodule

### rpm_window_acceleration_timer.f
hw/rtl/rwat_pkg.sv
hw/rtl/rwat_div.sv
hw/rtl/rpm_window_acceleration_timer.sv
test/rpm_window_acceleration_timer_tb.sv
